// ===== hw/rtl/lawc_pkg.sv =====
// Package for the lidar angular window crop: widths, CORDIC angle table, degree conversion.
// No dependencies.
`timescale 1ns / 1ps
package lawc_pkg;
  localparam int CoordWidth   = 19;
  localparam int AngleBits    = 16;
  localparam int CordicStages = 16;
  localparam int YawBits      = 16;
  localparam int TabFrac      = 32;
  localparam int SumWidth     = 2 * CoordWidth;
  localparam int RootWidth    = 31;
  localparam int CordWidth    = 36;
  localparam int AngWidth     = 34;

  localparam logic [1:0] RegPitchMin = 2'd0;
  localparam logic [1:0] RegPitchMax = 2'd1;
  localparam logic [1:0] RegYawMin   = 2'd2;
  localparam logic [1:0] RegYawMax   = 2'd3;

  // ceil(2^28 / 45), exact quotient for numerators below 2^22
  localparam logic [22:0] Recip45 = 23'd5965233;

  typedef struct packed {
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
    logic signed [CoordWidth-1:0] z;
    logic [7:0]                   level;
    logic [YawBits-1:0]           yaw;
  } point_t;

  function automatic logic signed [AngWidth-1:0] stage_angle(input logic [4:0] i);
    logic signed [AngWidth-1:0] a;
    case (i)
      5'd0:  a = 34'sd536870912;
      5'd1:  a = 34'sd316933406;
      5'd2:  a = 34'sd167458907;
      5'd3:  a = 34'sd85004756;
      5'd4:  a = 34'sd42667331;
      5'd5:  a = 34'sd21354465;
      5'd6:  a = 34'sd10679838;
      5'd7:  a = 34'sd5340245;
      5'd8:  a = 34'sd2670163;
      5'd9:  a = 34'sd1335087;
      5'd10: a = 34'sd667544;
      5'd11: a = 34'sd333772;
      5'd12: a = 34'sd166886;
      5'd13: a = 34'sd83443;
      5'd14: a = 34'sd41722;
      5'd15: a = 34'sd20861;
      5'd16: a = 34'sd10430;
      5'd17: a = 34'sd5215;
      5'd18: a = 34'sd2608;
      5'd19: a = 34'sd1304;
      5'd20: a = 34'sd652;
      5'd21: a = 34'sd326;
      5'd22: a = 34'sd163;
      5'd23: a = 34'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

  // round(deg * 65536 / 360), halves away from zero; deg is 10-bit signed.
  // (deg * 65536 + 180) / 8 = deg * 8192 + 22, then divide by 45 by reciprocal.
  function automatic logic signed [19:0] deg_code(input logic signed [9:0] deg);
    logic [9:0]  m;
    logic [21:0] t;
    logic [44:0] prod;
    logic [19:0] q;
    m    = deg[9] ? 10'(-deg) : 10'(deg);
    t    = {m[8:0], 13'd0} + 22'd22;
    prod = 45'(t) * 45'(Recip45);
    q    = 20'(prod >> 28);
    return deg[9] ? -q : q;
  endfunction
endpackage

// ===== hw/rtl/lawc_front.sv =====
// Front end: squares, normalising shift, integer square root stages.
// Depends on lawc_pkg.
`timescale 1ns / 1ps
module lawc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  lawc_pkg::point_t               pt_i,
  output logic                           valid_o,
  output lawc_pkg::point_t               pt_o,
  output logic [lawc_pkg::RootWidth-1:0] root_o,
  output logic signed [lawc_pkg::CordWidth-1:0] zz_o,
  output logic                           axis_o
);
  import lawc_pkg::*;

  localparam int RootSteps = 32;

  // stage 1: squares
  logic             v1_q;
  point_t           p1_q;
  logic [SumWidth:0] s1_q;
  logic [CoordWidth-1:0] az1_q;
  logic [CoordWidth-1:0] ax, ay, az;

  assign ax = pt_i.x[CoordWidth-1] ? CoordWidth'(-pt_i.x) : pt_i.x;
  assign ay = pt_i.y[CoordWidth-1] ? CoordWidth'(-pt_i.y) : pt_i.y;
  assign az = pt_i.z[CoordWidth-1] ? CoordWidth'(-pt_i.z) : pt_i.z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en_i) v1_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q  <= pt_i;
      s1_q  <= (SumWidth+1)'(ax) * (SumWidth+1)'(ax) + (SumWidth+1)'(ay) * (SumWidth+1)'(ay);
      az1_q <= az;
    end
  end

  // stage 2: normalising shift
  logic [4:0]  f;
  logic        stop;

  always_comb begin
    f = '0;
    stop = 1'b0;
    for (int k = 0; k < 31; k++) begin
      if (!stop && 64'(s1_q) < (64'd1 << (60 - 2 * k)) &&
          64'(az1_q) < (64'd1 << (31 - k)))
        f = 5'(k + 1);
      else
        stop = 1'b1;
    end
  end

  // square root: one result bit per stage, entry 0 holds the shifted operands
  logic        vr_q  [RootSteps+1];
  point_t      pr_q  [RootSteps+1];
  logic [63:0] rem_q [RootSteps+1];
  logic [63:0] res_q [RootSteps+1];
  logic signed [CordWidth-1:0] zr_q [RootSteps+1];
  logic        axr_q [RootSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= RootSteps; k++) vr_q[k] <= 1'b0;
    end else if (en_i) begin
      vr_q[0] <= v1_q;
      for (int k = 0; k < RootSteps; k++) vr_q[k+1] <= vr_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q[0]  <= p1_q;
      rem_q[0] <= 64'(s1_q) << {f, 1'b0};
      res_q[0] <= '0;
      zr_q[0]  <= p1_q.z[CoordWidth-1] ? -(CordWidth'(az1_q) << f)
                                       : (CordWidth'(az1_q) << f);
      axr_q[0] <= (s1_q == '0);
      for (int k = 0; k < RootSteps; k++) begin
        pr_q[k+1]  <= pr_q[k];
        zr_q[k+1]  <= zr_q[k];
        axr_q[k+1] <= axr_q[k];
        if (rem_q[k] >= res_q[k] + (64'd1 << (62 - 2 * k))) begin
          rem_q[k+1] <= rem_q[k] - (res_q[k] + (64'd1 << (62 - 2 * k)));
          res_q[k+1] <= (res_q[k] >> 1) + (64'd1 << (62 - 2 * k));
        end else begin
          rem_q[k+1] <= rem_q[k];
          res_q[k+1] <= res_q[k] >> 1;
        end
      end
    end
  end

  assign valid_o = vr_q[RootSteps];
  assign pt_o    = pr_q[RootSteps];
  assign root_o  = RootWidth'(res_q[RootSteps]);
  assign zz_o    = zr_q[RootSteps];
  assign axis_o  = axr_q[RootSteps];
endmodule

// ===== hw/rtl/lawc_cordic.sv =====
// Pipelined vectoring CORDIC, one stage per register, plus final angle rounding.
// Depends on lawc_pkg.
`timescale 1ns / 1ps
module lawc_cordic (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  lawc_pkg::point_t               pt_i,
  input  logic [lawc_pkg::RootWidth-1:0] root_i,
  input  logic signed [lawc_pkg::CordWidth-1:0] zz_i,
  input  logic                           axis_i,
  output logic                           valid_o,
  output lawc_pkg::point_t               pt_o,
  output logic signed [lawc_pkg::AngleBits:0] pitch_o,
  output logic                           drop_o
);
  import lawc_pkg::*;

  // entry 0 is the input register, entry k the result of stage k-1
  logic   v_q  [CordicStages+1];
  point_t p_q  [CordicStages+1];
  logic signed [CordWidth-1:0] cx_q [CordicStages+1];
  logic signed [CordWidth-1:0] cy_q [CordicStages+1];
  logic signed [AngWidth-1:0]  an_q [CordicStages+1];
  logic   ax_q [CordicStages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= CordicStages; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 0; k < CordicStages; k++) v_q[k+1] <= v_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0]  <= pt_i;
      cx_q[0] <= CordWidth'(root_i);
      cy_q[0] <= zz_i;
      an_q[0] <= '0;
      ax_q[0] <= axis_i;
      for (int k = 0; k < CordicStages; k++) begin
        p_q[k+1]  <= p_q[k];
        ax_q[k+1] <= ax_q[k];
        if (!cy_q[k][CordWidth-1]) begin
          cx_q[k+1] <= cx_q[k] + (cy_q[k] >>> k);
          cy_q[k+1] <= cy_q[k] - (cx_q[k] >>> k);
          an_q[k+1] <= an_q[k] + stage_angle(5'(k));
        end else begin
          cx_q[k+1] <= cx_q[k] - (cy_q[k] >>> k);
          cy_q[k+1] <= cy_q[k] + (cx_q[k] >>> k);
          an_q[k+1] <= an_q[k] - stage_angle(5'(k));
        end
      end
    end
  end

  logic signed [AngWidth-1:0] rnd;
  logic signed [AngleBits:0]  quarter;
  assign rnd     = (an_q[CordicStages] + (AngWidth'(1) <<< (TabFrac - AngleBits - 1)))
                   >>> (TabFrac - AngleBits);
  assign quarter = (AngleBits+1)'(1) <<< (AngleBits - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (en_i) valid_o <= v_q[CordicStages];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pt_o <= p_q[CordicStages];
      drop_o <= ax_q[CordicStages] && (p_q[CordicStages].z == '0);
      if (ax_q[CordicStages])
        pitch_o <= p_q[CordicStages].z[CoordWidth-1] ? -quarter : quarter;
      else
        pitch_o <= (AngleBits+1)'(rnd);
    end
  end
endmodule

// ===== hw/rtl/lawc_window.sv =====
// Window test against the converted limits and output register stage.
// Depends on lawc_pkg.
`timescale 1ns / 1ps
module lawc_window (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  lawc_pkg::point_t               pt_i,
  input  logic signed [lawc_pkg::AngleBits:0] pitch_i,
  input  logic                           drop_i,
  input  logic signed [19:0]             pmin_i,
  input  logic signed [19:0]             pmax_i,
  input  logic signed [19:0]             ymin_i,
  input  logic signed [19:0]             ymax_i,
  input  logic                           wrap_i,
  output logic                           valid_o,
  output lawc_pkg::point_t               pt_o
);
  import lawc_pkg::*;

  logic signed [19:0] p, yw;
  logic pitch_ok, yaw_ok;
  assign p  = 20'(pitch_i);
  assign yw = 20'(pt_i.yaw);
  assign pitch_ok = (p < pmax_i) && (p > pmin_i);
  assign yaw_ok   = wrap_i ? ((yw > ymin_i) || (yw < ymax_i && yw > 0))
                           : ((yw < ymax_i) && (yw > ymin_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (en_i) valid_o <= valid_i && !drop_i && pitch_ok && yaw_ok;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) pt_o <= pt_i;
  end
endmodule

// ===== hw/rtl/lidar_angular_window_crop_core.sv =====
// Pipeline stages from input request to output: squares, shift, 32 root,
// CORDIC input register, 16 CORDIC, rounding, window. Throughput: one point per cycle.
// Whole pipeline stalls together while the output holds an unaccepted point.
// Reset: asynchronous active low; clears valid bits and sets default limits.
// Depends on lawc_pkg, lawc_front, lawc_cordic, lawc_window.
`timescale 1ns / 1ps
module lidar_angular_window_crop_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // pos_x, pos_y, pos_z, echo_level, yaw_turns
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // kept_x, kept_y, kept_z, kept_level, kept_yaw
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_data_i
);
  import lawc_pkg::*;

  logic [7:0] pmin_q, pmax_q;
  logic [8:0] ymin_q, ymax_q;
  logic signed [19:0] pmin_code_q, pmax_code_q, ymin_code_q, ymax_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmin_q <= 8'hA6;
      pmax_q <= 8'd90;
      ymin_q <= 9'd0;
      ymax_q <= 9'd360;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPitchMin: pmin_q <= cfg_data_i[7:0];
        RegPitchMax: pmax_q <= cfg_data_i[7:0];
        RegYawMin:   ymin_q <= cfg_data_i;
        RegYawMax:   ymax_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    pmin_code_q <= deg_code(10'(signed'(pmin_q)));
    pmax_code_q <= deg_code(10'(signed'(pmax_q)));
    ymin_code_q <= deg_code(signed'({1'b0, ymin_q}));
    ymax_code_q <= deg_code(signed'({1'b0, ymax_q}));
  end

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  point_t pin;
  assign pin.x     = s_axis_tdata[18:0];
  assign pin.y     = s_axis_tdata[37:19];
  assign pin.z     = s_axis_tdata[56:38];
  assign pin.level = s_axis_tdata[64:57];
  assign pin.yaw   = s_axis_tdata[80:65];

  point_t pf, pc, po;
  logic vf, vc, axis, drop;
  logic [RootWidth-1:0] root;
  logic signed [CordWidth-1:0] zz;
  logic signed [AngleBits:0] pitch;

  lawc_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid && en),
    .pt_i(pin), .valid_o(vf), .pt_o(pf), .root_o(root), .zz_o(zz), .axis_o(axis)
  );
  lawc_cordic u_cordic (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vf), .pt_i(pf), .root_i(root),
    .zz_i(zz), .axis_i(axis), .valid_o(vc), .pt_o(pc), .pitch_o(pitch), .drop_o(drop)
  );
  lawc_window u_window (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vc), .pt_i(pc), .pitch_i(pitch),
    .drop_i(drop), .pmin_i(pmin_code_q), .pmax_i(pmax_code_q), .ymin_i(ymin_code_q),
    .ymax_i(ymax_code_q), .wrap_i(ymin_q > ymax_q), .valid_o(m_axis_tvalid), .pt_o(po)
  );

  assign m_axis_tdata = {7'd0, po.yaw, po.level, po.z, po.y, po.x};
endmodule

// ===== hw/rtl/lawc_checker.sv =====
// Port-level checker for the crop core, bound to the top level.
// Depends on lidar_angular_window_crop_core.
`timescale 1ns / 1ps
module lawc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready mismatch");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[87:81] == 7'd0)
    else $error("pad bits set");
endmodule

bind lidar_angular_window_crop_core lawc_checker u_lawc_checker (.*);
